>>> rtl/core/pdh_pkg.sv
// ----------------------------------------------------------------------------
// pdh_pkg: shared definitions for the pair distance histogram
// widths, limits, action and status codes, controller/datapath signal groups
// ----------------------------------------------------------------------------
package pdh_pkg;

	// storage limits
	localparam int MAX_POINTS = 16384;
	localparam int MAX_BINS   = 128;
	localparam int COORD_BITS = 24;

	// item field widths
	localparam int ACT_W      = 3;
	localparam int IDX_W      = 14;
	localparam int COORD_IN_W = 24;
	localparam int EDGE_W     = 24;
	localparam int STATUS_W   = 2;
	localparam int HIT_W      = 7;
	localparam int COUNT_W    = 32;
	localparam int DIST_W     = 50;

	// configuration port
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 15;
	localparam int CFG_BINS_W   = 8;
	localparam int CFG_POINTS_W = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE = CFG_IDX_W'(1);

	// derived internal widths
	localparam int PT_AW   = $clog2(MAX_POINTS);
	localparam int BIN_AW  = $clog2(MAX_BINS);
	localparam int SCAN_W  = $clog2(MAX_BINS + 1);
	localparam int NP_W    = $clog2(MAX_POINTS + 1);
	localparam int ABS_W   = COORD_BITS;
	localparam int SQ_W    = 2 * COORD_BITS;
	localparam int DSUM_W  = 2 * COORD_BITS + 2;
	localparam int EDGE2_W = 2 * EDGE_W;
	localparam int CMP_W   = (DSUM_W > EDGE2_W) ? DSUM_W : EDGE2_W;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD_POINT   = 3'd0,
		ACT_LOAD_EDGE    = 3'd1,
		ACT_COUNT_PAIR   = 3'd2,
		ACT_READ_COUNT   = 3'd3,
		ACT_CLEAR_COUNTS = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 2'd0,
		ST_NO_BIN = 2'd1,
		ST_EQUAL  = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	// which result the output register is loaded with
	typedef enum logic [1:0] {
		RK_PLAIN = 2'd0,
		RK_READ  = 2'd1,
		RK_HIT   = 2'd2,
		RK_MISS  = 2'd3
	} res_kind_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} point_t;

	// controller to datapath
	typedef struct packed {
		logic      capture;
		logic      exec;
		logic      rd_second;
		logic      diff_en;
		logic      sq_en;
		logic      sum_en;
		logic      scan_start;
		logic      scan;
		logic      cnt_rd_hit;
		logic      cnt_wr;
		logic      load_out;
		res_kind_t res_kind;
	} pdh_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             early_ok;
		logic             scan_hit;
		logic             scan_miss;
	} pdh_stat_t;

endpackage

>>> rtl/core/pdh_if.sv
// ----------------------------------------------------------------------------
// pdh_if: item and result channels of the pair distance histogram
// valid/ready channels, a beat moves when both are high at a clock edge
// ----------------------------------------------------------------------------
interface pdh_in_if import pdh_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [ACT_W-1:0]             action;
	logic [IDX_W-1:0]             first_index;
	logic [IDX_W-1:0]             second_index;
	logic signed [COORD_IN_W-1:0] coord_x;
	logic signed [COORD_IN_W-1:0] coord_y;
	logic signed [COORD_IN_W-1:0] coord_z;
	logic [EDGE_W-1:0]            edge_value;

	modport source (
		output valid, action, first_index, second_index, coord_x, coord_y, coord_z,
			edge_value,
		input  ready
	);
	modport sink (
		input  valid, action, first_index, second_index, coord_x, coord_y, coord_z,
			edge_value,
		output ready
	);
endinterface

interface pdh_out_if import pdh_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HIT_W-1:0]    bin_hit;
	logic [COUNT_W-1:0]  count_value;
	logic [DIST_W-1:0]   distance_squared;

	modport source (
		output valid, status, bin_hit, count_value, distance_squared,
		input  ready
	);
	modport sink (
		input  valid, status, bin_hit, count_value, distance_squared,
		output ready
	);
endinterface

>>> rtl/core/pair_distance_histogram.sv
// ----------------------------------------------------------------------------
// pair_distance_histogram: pair-count histogram for two-point correlation
// point store, bin edge table and saturating per-bin counts
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one item per beat: load point, load bin edge, count pair,
//   read bin count or clear counts. out_ch returns exactly one result beat
//   per item, in order. cfg_we/cfg_index/cfg_data set bins_in_use (index 0)
//   and points_in_use (index 1); write them only while no item is in flight.
//   one item is worked at a time. loads, reads, clears and rejected pairs
//   go from the checks straight to the result. a pair runs the checks,
//   point reads, difference, square and sum, then walks the edges of the
//   first bins_in_use bins (capped at 128); the walk reads one edge per
//   cycle through two pipeline stages (edge read, edge square) ahead of
//   the compare, a pair that no edge covers gets no bin, and a hit adds a
//   count read and a count write. the next item is taken in the cycle
//   after its result is loaded. the result sits in an output register,
//   so a new item is taken while the previous result waits; the following
//   result waits in the controller until out_ch is free, and in_ch stalls
//   meanwhile.
//   reset clears the control, configuration and scan registers and all bin
//   counts (per-bin valid bits); points and edges are undefined until loaded.
// ----------------------------------------------------------------------------
module pair_distance_histogram import pdh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	pdh_in_if.sink                in_ch,
	pdh_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	pdh_cmd_t  cmd;
	pdh_stat_t stat;

	// sequencer: takes item beats, steps the datapath, holds result valid
	pdh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// stores, distance math, bin walk and the result register
	pdh_datapath u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.stat                 (stat),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.in_action            (in_ch.action),
		.in_first_index       (in_ch.first_index),
		.in_second_index      (in_ch.second_index),
		.in_coord_x           (in_ch.coord_x),
		.in_coord_y           (in_ch.coord_y),
		.in_coord_z           (in_ch.coord_z),
		.in_edge_value        (in_ch.edge_value),
		.res_status           (out_ch.status),
		.res_bin_hit          (out_ch.bin_hit),
		.res_count_value      (out_ch.count_value),
		.res_distance_squared (out_ch.distance_squared)
	);

endmodule

>>> rtl/core/pdh_datapath.sv
// ----------------------------------------------------------------------------
// pdh_datapath: stores, distance arithmetic and bin scan
// point/edge/count memories, squared distance, pipelined edge walk
// ----------------------------------------------------------------------------
module pdh_datapath import pdh_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pdh_cmd_t                     cmd,
	output pdh_stat_t                    stat,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic [ACT_W-1:0]             in_action,
	input  logic [IDX_W-1:0]             in_first_index,
	input  logic [IDX_W-1:0]             in_second_index,
	input  logic signed [COORD_IN_W-1:0] in_coord_x,
	input  logic signed [COORD_IN_W-1:0] in_coord_y,
	input  logic signed [COORD_IN_W-1:0] in_coord_z,
	input  logic [EDGE_W-1:0]            in_edge_value,
	output logic [STATUS_W-1:0]          res_status,
	output logic [HIT_W-1:0]             res_bin_hit,
	output logic [COUNT_W-1:0]           res_count_value,
	output logic [DIST_W-1:0]            res_distance_squared
);

	function automatic logic [ABS_W-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] d;
		d = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
		if (d < 0)
			d = -d;
		return d[ABS_W-1:0];
	endfunction

	// configuration
	logic [CFG_BINS_W-1:0]   bins_in_use_q;
	logic [CFG_POINTS_W-1:0] points_in_use_q;

	// captured item
	logic [ACT_W-1:0]  action_q;
	logic [IDX_W-1:0]  i1_q;
	logic [IDX_W-1:0]  i2_q;
	point_t            pt_in_q;
	logic [EDGE_W-1:0] edge_in_q;

	// stores
	point_t             pt_mem [MAX_POINTS];
	logic [EDGE_W-1:0]  edge_mem [MAX_BINS];
	logic [COUNT_W-1:0] cnt_mem [MAX_BINS];
	logic [MAX_BINS-1:0] cnt_vld_q;

	point_t             pt_rd_q;
	point_t             p1_q;
	logic [PT_AW-1:0]   pt_raddr;
	logic [COUNT_W-1:0] cnt_rd_q;
	logic [BIN_AW-1:0]  cnt_raddr;

	// distance
	logic [ABS_W-1:0]  ax_q, ay_q, az_q;
	logic [SQ_W-1:0]   sx_q, sy_q, sz_q;
	logic [DSUM_W-1:0] dist_q;

	// bin scan
	logic [SCAN_W-1:0]  scan_addr_q;
	logic [SCAN_W-1:0]  nb;
	logic [NP_W-1:0]    np;
	logic               issue;
	logic               v_s1, v_s2;
	logic [EDGE_W-1:0]  edge_s1;
	logic [BIN_AW-1:0]  bin_s1, bin_s2;
	logic [EDGE2_W-1:0] edge2_s2;
	logic               scan_hit, scan_miss;
	logic [BIN_AW-1:0]  hit_bin_q;

	// count update
	logic [COUNT_W-1:0] cnt_old, cnt_inc, cnt_new_q, read_val;

	status_t early_status;
	logic    wr_point, wr_edge, clr_counts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_in_use_q   <= '0;
			points_in_use_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BINS_IN_USE:   bins_in_use_q   <= cfg_data[CFG_BINS_W-1:0];
				CFG_POINTS_IN_USE: points_in_use_q <= cfg_data[CFG_POINTS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q    <= in_action;
			i1_q        <= in_first_index;
			i2_q        <= in_second_index;
			pt_in_q.x   <= COORD_BITS'(in_coord_x);
			pt_in_q.y   <= COORD_BITS'(in_coord_y);
			pt_in_q.z   <= COORD_BITS'(in_coord_z);
			edge_in_q   <= in_edge_value;
		end
	end

	// effective limits, register values above the store size saturate
	assign nb = (int'(bins_in_use_q) > MAX_BINS) ? SCAN_W'(MAX_BINS) : SCAN_W'(bins_in_use_q);
	assign np = (int'(points_in_use_q) > MAX_POINTS) ? NP_W'(MAX_POINTS) :
		NP_W'(points_in_use_q);

	always_comb begin
		early_status = ST_DONE;
		case (action_q)
			ACT_LOAD_POINT:
				if (int'(i1_q) >= MAX_POINTS)
					early_status = ST_RANGE;
			ACT_LOAD_EDGE, ACT_READ_COUNT:
				if (int'(i1_q) >= MAX_BINS)
					early_status = ST_RANGE;
			ACT_COUNT_PAIR:
				if (int'(i1_q) >= int'(np) || int'(i2_q) >= int'(np))
					early_status = ST_RANGE;
				else if (i1_q == i2_q)
					early_status = ST_EQUAL;
			default: ;
		endcase
	end

	assign wr_point   = cmd.exec && (action_q == ACT_LOAD_POINT) && (early_status == ST_DONE);
	assign wr_edge    = cmd.exec && (action_q == ACT_LOAD_EDGE) && (early_status == ST_DONE);
	assign clr_counts = cmd.exec && (action_q == ACT_CLEAR_COUNTS);

	// point store, one write and one read port
	assign pt_raddr = cmd.rd_second ? PT_AW'(i2_q) : PT_AW'(i1_q);

	always_ff @(posedge clk) begin
		if (wr_point)
			pt_mem[PT_AW'(i1_q)] <= pt_in_q;
	end

	always_ff @(posedge clk) begin
		pt_rd_q <= pt_mem[pt_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_second)
			p1_q <= pt_rd_q;
		if (cmd.diff_en) begin
			ax_q <= abs_diff(p1_q.x, pt_rd_q.x);
			ay_q <= abs_diff(p1_q.y, pt_rd_q.y);
			az_q <= abs_diff(p1_q.z, pt_rd_q.z);
		end
		if (cmd.sq_en) begin
			sx_q <= ax_q * ax_q;
			sy_q <= ay_q * ay_q;
			sz_q <= az_q * az_q;
		end
		if (cmd.sum_en)
			dist_q <= DSUM_W'(sx_q) + DSUM_W'(sy_q) + DSUM_W'(sz_q);
	end

	// edge table
	always_ff @(posedge clk) begin
		if (wr_edge)
			edge_mem[BIN_AW'(i1_q)] <= edge_in_q;
	end

	always_ff @(posedge clk) begin
		edge_s1 <= edge_mem[scan_addr_q[BIN_AW-1:0]];
	end

	// scan: address, edge read, edge square, compare
	assign issue     = cmd.scan && (scan_addr_q < nb);
	assign scan_hit  = cmd.scan && v_s2 && (CMP_W'(dist_q) <= CMP_W'(edge2_s2));
	assign scan_miss = cmd.scan && !issue && !v_s1 && !v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_addr_q <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
		end else begin
			if (issue)
				scan_addr_q <= scan_addr_q + 1'b1;
			v_s1 <= issue;
			v_s2 <= v_s1 && cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		bin_s1   <= scan_addr_q[BIN_AW-1:0];
		bin_s2   <= bin_s1;
		edge2_s2 <= edge_s1 * edge_s1;
		if (scan_hit)
			hit_bin_q <= bin_s2;
	end

	// bin counts, entries without a valid bit read as zero
	assign cnt_raddr = cmd.cnt_rd_hit ? hit_bin_q : BIN_AW'(i1_q);
	assign cnt_old   = cnt_vld_q[hit_bin_q] ? cnt_rd_q : '0;
	assign cnt_inc   = (&cnt_old) ? cnt_old : cnt_old + 1'b1;
	assign read_val  = cnt_vld_q[BIN_AW'(i1_q)] ? cnt_rd_q : '0;

	always_ff @(posedge clk) begin
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.cnt_wr)
			cnt_mem[hit_bin_q] <= cnt_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_vld_q <= '0;
		else if (clr_counts)
			cnt_vld_q <= '0;
		else if (cmd.cnt_wr)
			cnt_vld_q[hit_bin_q] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.cnt_wr)
			cnt_new_q <= cnt_inc;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			case (cmd.res_kind)
				RK_READ: begin
					res_status           <= ST_DONE;
					res_bin_hit          <= '0;
					res_count_value      <= read_val;
					res_distance_squared <= '0;
				end
				RK_HIT: begin
					res_status           <= ST_DONE;
					res_bin_hit          <= HIT_W'(hit_bin_q);
					res_count_value      <= cnt_new_q;
					res_distance_squared <= DIST_W'(dist_q);
				end
				RK_MISS: begin
					res_status           <= ST_NO_BIN;
					res_bin_hit          <= '0;
					res_count_value      <= '0;
					res_distance_squared <= DIST_W'(dist_q);
				end
				default: begin
					res_status           <= early_status;
					res_bin_hit          <= '0;
					res_count_value      <= '0;
					res_distance_squared <= '0;
				end
			endcase
		end
	end

	assign stat.action    = action_q;
	assign stat.early_ok  = (early_status == ST_DONE);
	assign stat.scan_hit  = scan_hit;
	assign stat.scan_miss = scan_miss;

endmodule

>>> rtl/core/pdh_ctrl.sv
// ----------------------------------------------------------------------------
// pdh_ctrl: sequencer of the pair distance histogram
// one item at a time, steps the datapath and owns the result valid
// ----------------------------------------------------------------------------
module pdh_ctrl import pdh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  pdh_stat_t stat,
	output pdh_cmd_t  cmd
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_EXEC   = 10'b0000000010,
		S_RD2    = 10'b0000000100,
		S_DIFF   = 10'b0000001000,
		S_SQ     = 10'b0000010000,
		S_SUM    = 10'b0000100000,
		S_SCAN   = 10'b0001000000,
		S_CNT_RD = 10'b0010000000,
		S_CNT_WR = 10'b0100000000,
		S_FINISH = 10'b1000000000
	} state_t;

	state_t    state_q, state_d;
	res_kind_t res_kind_q, res_kind_d;
	logic      out_valid_q;
	logic      out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		res_kind_d   = res_kind_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.res_kind = res_kind_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.action == ACT_COUNT_PAIR && stat.early_ok) begin
					state_d = S_RD2;
				end else begin
					res_kind_d = (stat.action == ACT_READ_COUNT && stat.early_ok) ?
						RK_READ : RK_PLAIN;
					state_d    = S_FINISH;
				end
			end
			S_RD2: begin
				cmd.rd_second = 1'b1;
				state_d       = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff_en = 1'b1;
				state_d     = S_SQ;
			end
			S_SQ: begin
				cmd.sq_en = 1'b1;
				state_d   = S_SUM;
			end
			S_SUM: begin
				cmd.sum_en     = 1'b1;
				cmd.scan_start = 1'b1;
				state_d        = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_hit) begin
					res_kind_d = RK_HIT;
					state_d    = S_CNT_RD;
				end else if (stat.scan_miss) begin
					res_kind_d = RK_MISS;
					state_d    = S_FINISH;
				end
			end
			S_CNT_RD: begin
				cmd.cnt_rd_hit = 1'b1;
				state_d        = S_CNT_WR;
			end
			S_CNT_WR: begin
				cmd.cnt_wr = 1'b1;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			res_kind_q <= RK_PLAIN;
		end else begin
			state_q    <= state_d;
			res_kind_q <= res_kind_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;

endmodule

>>> bench/pair_distance_histogram_test.sv
// ----------------------------------------------------------------------------
// pair_distance_histogram_test: self-checking bench for the pair histogram
// drives load, edge, pair, read, clear and unused-action beats with random
// handshake gaps, predicts every result beat in-bench and compares field by
// field, under several bins_in_use / points_in_use settings
// ----------------------------------------------------------------------------
module pair_distance_histogram_test import pdh_pkg::*; ();

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_HOLD   = 400;
	// edge ramp spans the distances of the clustered points
	localparam int EDGE_SPAN   = 320000;
	localparam int CLUSTER     = 65536;
	localparam logic signed [COORD_IN_W-1:0] COORD_MIN = {1'b1, {(COORD_IN_W-1){1'b0}}};
	localparam logic signed [COORD_IN_W-1:0] COORD_MAX = {1'b0, {(COORD_IN_W-1){1'b1}}};
	localparam logic [EDGE_W-1:0] EDGE_TOP = '1;
	// first action code past the defined ones, ignored by the block
	localparam logic [ACT_W-1:0] ACT_UNUSED_LO = ACT_W'(ACT_CLEAR_COUNTS + 1);

	typedef struct {
		logic [ACT_W-1:0]             action;
		logic [IDX_W-1:0]             first_index;
		logic [IDX_W-1:0]             second_index;
		logic signed [COORD_IN_W-1:0] coord_x;
		logic signed [COORD_IN_W-1:0] coord_y;
		logic signed [COORD_IN_W-1:0] coord_z;
		logic [EDGE_W-1:0]            edge_value;
	} item_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [HIT_W-1:0]    bin_hit;
		logic [COUNT_W-1:0]  count_value;
		logic [DIST_W-1:0]   distance_squared;
	} result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pdh_in_if  item_ch();
	pdh_out_if result_ch();

	pair_distance_histogram dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (item_ch),
		.out_ch    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// bench copy of the histogram state
	point_t                  point_mem [MAX_POINTS];
	logic [EDGE_W-1:0]       edge_mem [MAX_BINS];
	logic [COUNT_W-1:0]      count_mem [MAX_BINS];
	logic [CFG_BINS_W-1:0]   cfg_bins;
	logic [CFG_POINTS_W-1:0] cfg_points;
	// points loaded so far, so pairs only ever touch written entries
	bit                      point_written [MAX_POINTS];
	int                      written_points [$];
	// edges loaded so far, so a full table is not loaded twice
	bit                      edge_written [MAX_BINS];

	result_t predicted_results [$];

	int sender_idle_pct      = 0;
	int receiver_idle_pct    = 0;
	int receiver_hold_cycles = 0;
	int failures             = 0;
	int items_sent           = 0;
	int cycle_count          = 0;
	int status_tally [4]     = '{0, 0, 0, 0};

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// values above the store size act as the store size
	function automatic int active_points();
		return (cfg_points < MAX_POINTS) ? int'(cfg_points) : MAX_POINTS;
	endfunction

	function automatic int active_bins();
		return (cfg_bins < MAX_BINS) ? int'(cfg_bins) : MAX_BINS;
	endfunction

	function automatic longint unsigned axis_square(input logic signed [COORD_BITS-1:0] a,
			input logic signed [COORD_BITS-1:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		if (d < 0) begin
			d = -d;
		end
		return longint'(d * d);
	endfunction

	// works out the result beat of one accepted item and updates the state
	function automatic result_t histogram_predict(input item_t it);
		result_t         r;
		int              np;
		int              nb;
		longint unsigned d2;
		longint unsigned e;
		point_t          p;
		point_t          q;
		r.status           = ST_DONE;
		r.bin_hit          = '0;
		r.count_value      = '0;
		r.distance_squared = '0;
		np = active_points();
		nb = active_bins();
		case (it.action)
			ACT_LOAD_POINT: begin
				if (int'(it.first_index) < MAX_POINTS) begin
					point_mem[it.first_index] = '{it.coord_x, it.coord_y, it.coord_z};
					if (!point_written[it.first_index]) begin
						point_written[it.first_index] = 1'b1;
						written_points.push_back(int'(it.first_index));
					end
				end else begin
					r.status = ST_RANGE;
				end
			end
			ACT_LOAD_EDGE: begin
				if (int'(it.first_index) < MAX_BINS) begin
					edge_mem[it.first_index]     = it.edge_value;
					edge_written[it.first_index] = 1'b1;
				end else begin
					r.status = ST_RANGE;
				end
			end
			ACT_COUNT_PAIR: begin
				// range is checked ahead of equality
				if (int'(it.first_index) >= np || int'(it.second_index) >= np) begin
					r.status = ST_RANGE;
				end else if (it.first_index == it.second_index) begin
					r.status = ST_EQUAL;
				end else begin
					p  = point_mem[it.first_index];
					q  = point_mem[it.second_index];
					d2 = axis_square(p.x, q.x) + axis_square(p.y, q.y) + axis_square(p.z, q.z);
					r.distance_squared = d2[DIST_W-1:0];
					r.status = ST_NO_BIN;
					// first bin in table order whose squared edge covers the distance
					for (int b = 0; b < nb; b++) begin
						e = edge_mem[b];
						if (d2 <= e * e) begin
							if (count_mem[b] != '1) begin
								count_mem[b] = count_mem[b] + 1'b1;
							end
							r.status      = ST_DONE;
							r.bin_hit     = HIT_W'(b);
							r.count_value = count_mem[b];
							break;
						end
					end
				end
			end
			ACT_READ_COUNT: begin
				if (int'(it.first_index) < MAX_BINS) begin
					r.count_value = count_mem[it.first_index];
				end else begin
					r.status = ST_RANGE;
				end
			end
			ACT_CLEAR_COUNTS: begin
				foreach (count_mem[k]) begin
					count_mem[k] = '0;
				end
			end
			default: begin
				// unused action codes leave everything alone
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// item builders: every field random, then the ones that matter set
	// ------------------------------------------------------------------

	function automatic item_t random_fields();
		item_t it;
		it.action       = ACT_W'($urandom());
		it.first_index  = IDX_W'($urandom());
		it.second_index = IDX_W'($urandom());
		it.coord_x      = COORD_IN_W'($urandom());
		it.coord_y      = COORD_IN_W'($urandom());
		it.coord_z      = COORD_IN_W'($urandom());
		it.edge_value   = EDGE_W'($urandom());
		return it;
	endfunction

	function automatic item_t pair_item(input int first, input int second);
		item_t it;
		it              = random_fields();
		it.action       = ACT_COUNT_PAIR;
		it.first_index  = IDX_W'(first);
		it.second_index = IDX_W'(second);
		return it;
	endfunction

	function automatic item_t point_item(input int index, input logic signed [COORD_IN_W-1:0] x,
			input logic signed [COORD_IN_W-1:0] y, input logic signed [COORD_IN_W-1:0] z);
		item_t it;
		it             = random_fields();
		it.action      = ACT_LOAD_POINT;
		it.first_index = IDX_W'(index);
		it.coord_x     = x;
		it.coord_y     = y;
		it.coord_z     = z;
		return it;
	endfunction

	function automatic item_t edge_item(input int index, input logic [EDGE_W-1:0] value);
		item_t it;
		it             = random_fields();
		it.action      = ACT_LOAD_EDGE;
		it.first_index = IDX_W'(index);
		it.edge_value  = value;
		return it;
	endfunction

	// reads, clears and unused codes only look at first_index, if at all
	function automatic item_t bin_item(input logic [ACT_W-1:0] action, input int index);
		item_t it;
		it             = random_fields();
		it.action      = action;
		it.first_index = IDX_W'(index);
		return it;
	endfunction

	// ascending edges, so clustered pairs land across many bins
	function automatic logic [EDGE_W-1:0] ramp_edge(input int b);
		int nb;
		nb = (active_bins() > 0) ? active_bins() : 1;
		return EDGE_W'((b + 1) * (EDGE_SPAN / nb) + int'($urandom_range(255)));
	endfunction

	// mostly a small cluster near the origin, sometimes anywhere in range
	function automatic logic signed [COORD_IN_W-1:0] random_coord(input bit wide);
		if (wide) begin
			return COORD_IN_W'($urandom());
		end
		return COORD_IN_W'(int'($urandom_range(2 * CLUSTER)) - CLUSTER);
	endfunction

	// random mix, weighted toward pairs of loaded points
	function automatic item_t random_traffic_item();
		item_t it;
		int    np;
		int    nb;
		int    roll;
		int    a;
		int    c;
		bit    wide;
		int    usable [$];
		it   = random_fields();
		np   = active_points();
		nb   = active_bins();
		roll = $urandom_range(99);
		if (roll < 58) begin
			it.action = ACT_COUNT_PAIR;
			foreach (written_points[k]) begin
				if (written_points[k] < np) begin
					usable.push_back(written_points[k]);
				end
			end
			c = $urandom_range(99);
			if (c < 80 && usable.size() >= 2) begin
				a = $urandom_range(usable.size() - 1);
				roll = $urandom_range(usable.size() - 2);
				if (roll >= a) begin
					roll++;
				end
				it.first_index  = IDX_W'(usable[a]);
				it.second_index = IDX_W'(usable[roll]);
			end else if (c < 90 || np == MAX_POINTS) begin
				// same point twice, usually with an in-range index
				if (np > 0 && $urandom_range(3) != 0) begin
					it.first_index = IDX_W'($urandom_range(np - 1));
				end
				it.second_index = it.first_index;
			end else begin
				a = $urandom_range(MAX_POINTS - 1, np);
				if (c[0]) begin
					it.first_index = IDX_W'(a);
				end else begin
					it.second_index = IDX_W'(a);
				end
			end
		end else if (roll < 70) begin
			it.action = ACT_LOAD_POINT;
			if (written_points.size() != 0 && $urandom_range(1) == 1) begin
				it.first_index = IDX_W'(written_points[$urandom_range(written_points.size() - 1)]);
			end else if (np > 0) begin
				it.first_index = IDX_W'($urandom_range(np - 1));
			end
			wide = ($urandom_range(3) == 0);
			it.coord_x = random_coord(wide);
			it.coord_y = random_coord(wide);
			it.coord_z = random_coord(wide);
		end else if (roll < 78) begin
			it.action = ACT_LOAD_EDGE;
			if ($urandom_range(3) != 0) begin
				it.first_index = IDX_W'($urandom_range(MAX_BINS - 1));
				if (int'(it.first_index) < nb && $urandom_range(1) == 1) begin
					it.edge_value = ramp_edge(int'(it.first_index));
				end
			end
		end else if (roll < 90) begin
			it.action = ACT_READ_COUNT;
			if ($urandom_range(6) != 0) begin
				it.first_index = IDX_W'($urandom_range(MAX_BINS - 1));
			end
		end else if (roll < 94) begin
			it.action = ACT_CLEAR_COUNTS;
		end else begin
			it.action = ACT_W'($urandom_range(2 ** ACT_W - 1, ACT_UNUSED_LO));
		end
		return it;
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// one item beat; valid stays high on return so back-to-back beats need no gap
	task automatic send_item(input item_t it);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid        = 1'b1;
		item_ch.action       = it.action;
		item_ch.first_index  = it.first_index;
		item_ch.second_index = it.second_index;
		item_ch.coord_x      = it.coord_x;
		item_ch.coord_y      = it.coord_y;
		item_ch.coord_z      = it.coord_z;
		item_ch.edge_value   = it.edge_value;
		do @(posedge clk); while (!item_ch.ready);
		predicted_results.push_back(histogram_predict(it));
		items_sent++;
	endtask

	// stop offering beats and wait for every predicted result to come back
	task automatic wait_results_drained(input int max_cycles);
		int waited;
		waited = 0;
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (predicted_results.size() != 0 && waited < max_cycles) begin
			@(posedge clk);
			waited++;
		end
	endtask

	// register write, only called with nothing in flight
	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = index;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (index == CFG_BINS_IN_USE) begin
			cfg_bins = data[CFG_BINS_W-1:0];
		end else begin
			cfg_points = data[CFG_POINTS_W-1:0];
		end
	endtask

	// result side ready: random stalls, or a long hold when one is requested
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (receiver_hold_cycles > 0) begin
				receiver_hold_cycles--;
				result_ch.ready = 1'b0;
			end else begin
				result_ch.ready = ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// result checking: each accepted beat against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.status           = result_ch.status;
			got.bin_hit          = result_ch.bin_hit;
			got.count_value      = result_ch.count_value;
			got.distance_squared = result_ch.distance_squared;
			if (predicted_results.size() == 0) begin
				$error("result beat with nothing pending: status %0d", got.status);
				failures++;
			end else begin
				want = predicted_results.pop_front();
				status_tally[want.status]++;
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					failures++;
				end
				if (got.bin_hit !== want.bin_hit) begin
					$error("bin_hit: expected %0d, got %0d", want.bin_hit, got.bin_hit);
					failures++;
				end
				if (got.count_value !== want.count_value) begin
					$error("count_value: expected %0d, got %0d", want.count_value,
						got.count_value);
					failures++;
				end
				if (got.distance_squared !== want.distance_squared) begin
					$error("distance_squared: expected %0d, got %0d", want.distance_squared,
						got.distance_squared);
					failures++;
				end
			end
		end
	end

	// run-length guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("run stopped at cycle %0d, %0d results still pending", cycle_count,
				predicted_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// field extremes, every action and the corner statuses, in a known order
	task automatic test_directed_corners();
		// reset registers: no pair index is in range yet
		write_register(CFG_POINTS_IN_USE, '0);
		send_item(pair_item(0, 1));
		send_item(bin_item(ACT_READ_COUNT, 0));
		send_item(bin_item(ACT_READ_COUNT, MAX_BINS - 1));
		send_item(bin_item(ACT_READ_COUNT, MAX_BINS));
		send_item(bin_item(ACT_READ_COUNT, MAX_POINTS - 1));
		send_item(edge_item(MAX_BINS, EDGE_TOP));
		send_item(edge_item(MAX_POINTS - 1, '0));
		for (int a = int'(ACT_UNUSED_LO); a < 2 ** ACT_W; a++) begin
			send_item(bin_item(ACT_W'(a), $urandom_range(MAX_POINTS - 1)));
		end
		send_item(bin_item(ACT_CLEAR_COUNTS, $urandom_range(MAX_POINTS - 1)));
		// opposite corners of the coordinate range, and two coincident points
		send_item(point_item(MAX_POINTS - 1, COORD_MIN, COORD_MIN, COORD_MIN));
		send_item(point_item(0, COORD_MAX, COORD_MAX, COORD_MAX));
		send_item(point_item(1, '0, '0, '0));
		send_item(point_item(2, '0, '0, '0));

		// every index in range, no bins searched: largest distance, no bin
		wait_results_drained(CYCLE_LIMIT);
		write_register(CFG_BINS_IN_USE, '0);
		write_register(CFG_POINTS_IN_USE, '1);
		send_item(pair_item(0, MAX_POINTS - 1));
		send_item(pair_item(MAX_POINTS - 1, MAX_POINTS - 1));

		// two bins: zero edge takes coincident points, top edge the rest
		wait_results_drained(CYCLE_LIMIT);
		write_register(CFG_BINS_IN_USE, CFG_DATA_W'(2));
		send_item(edge_item(0, '0));
		send_item(edge_item(1, EDGE_TOP));
		send_item(pair_item(0, 1));
		send_item(pair_item(1, 2));
		send_item(pair_item(2, 1));
		send_item(bin_item(ACT_READ_COUNT, 0));
		// corner to corner exceeds even the top edge
		send_item(pair_item(0, MAX_POINTS - 1));
		send_item(bin_item(ACT_CLEAR_COUNTS, $urandom_range(MAX_POINTS - 1)));
		send_item(bin_item(ACT_READ_COUNT, 1));

		// two points in use: index 2 is just past the end
		wait_results_drained(CYCLE_LIMIT);
		write_register(CFG_POINTS_IN_USE, CFG_DATA_W'(2));
		send_item(pair_item(0, 2));
		send_item(pair_item(2, 0));
		send_item(pair_item(1, 0));
	endtask

	// one traffic phase: set registers, load edges and points, then random mix
	task automatic run_traffic_phase(input int send_pct, input int recv_pct,
			input logic [CFG_DATA_W-1:0] bins_data, input logic [CFG_DATA_W-1:0] points_data,
			input int point_loads, input int item_count, input bit hold_receiver,
			input bit pause_sender);
		int np;
		int index;
		wait_results_drained(CYCLE_LIMIT);
		sender_idle_pct   = send_pct;
		receiver_idle_pct = recv_pct;
		write_register(CFG_BINS_IN_USE, bins_data);
		write_register(CFG_POINTS_IN_USE, points_data);
		np = active_points();
		// every searched edge holds a value before any pair walks the table;
		// a full-size table keeps the edges that earlier phases loaded
		for (int b = 0; b < active_bins(); b++) begin
			if (!edge_written[b] || active_bins() < MAX_BINS) begin
				send_item(edge_item(b, ramp_edge(b)));
			end
		end
		for (int n = 0; n < point_loads; n++) begin
			if (np <= point_loads) begin
				index = n % np;
			end else if (n == 0) begin
				index = np - 1;
			end else begin
				index = $urandom_range(np - 1);
			end
			send_item(point_item(index, random_coord(n % 5 == 0), random_coord(n % 5 == 0),
				random_coord(n % 5 == 0)));
		end
		for (int n = 0; n < item_count; n++) begin
			// long result stall while items keep coming: fills the block
			if (hold_receiver && n == item_count / 3) begin
				receiver_hold_cycles = LONG_HOLD;
			end
			// sender goes quiet until the pipeline is empty, then resumes
			if (pause_sender && n == item_count / 2) begin
				wait_results_drained(CYCLE_LIMIT);
			end
			send_item(random_traffic_item());
		end
	endtask

	task automatic test_traffic_slow_receiver();
		run_traffic_phase(22, 60, CFG_DATA_W'(8), CFG_DATA_W'(24), 24, 50, 1'b1, 1'b0);
	endtask

	// upper bits above bins_in_use are dropped, leaving all 128 bins
	task automatic test_traffic_slow_sender();
		run_traffic_phase(60, 22, CFG_DATA_W'(16'h7F80), CFG_DATA_W'(64), 40, 50, 1'b0, 1'b1);
	endtask

	// bins_in_use past the store size, points_in_use at the store size, full-rate handshakes
	task automatic test_traffic_no_idle();
		run_traffic_phase(0, 0, '1, CFG_DATA_W'(MAX_POINTS), 32, 50, 1'b1, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		item_ch.valid        = 1'b0;
		item_ch.action       = '0;
		item_ch.first_index  = '0;
		item_ch.second_index = '0;
		item_ch.coord_x      = '0;
		item_ch.coord_y      = '0;
		item_ch.coord_z      = '0;
		item_ch.edge_value   = '0;
		cfg_bins             = '0;
		cfg_points           = '0;
		foreach (count_mem[k]) begin
			count_mem[k] = '0;
		end
		sender_idle_pct   = 22;
		receiver_idle_pct = 60;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_corners();
		test_traffic_slow_receiver();
		test_traffic_slow_sender();
		test_traffic_no_idle();

		// let the last results out, then watch for stray beats
		wait_results_drained(50000);
		repeat (200) @(posedge clk);
		if (predicted_results.size() != 0) begin
			$error("%0d predicted results never arrived", predicted_results.size());
			failures += predicted_results.size();
		end

		$display("run: %0d item beats over bins_in_use 0/2/8/128/255 and points_in_use"
			, items_sent);
		$display("0/2/24/64/16384/32767; results done %0d, no bin %0d, equal %0d, range %0d",
			status_tally[ST_DONE], status_tally[ST_NO_BIN], status_tally[ST_EQUAL],
			status_tally[ST_RANGE]);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
